@@ rtl/tape_language_interpreter_assert.svh @@
// Assertion macros shared by the interpreter RTL.
`ifndef TAPE_LANGUAGE_INTERPRETER_ASSERT_SVH
`define TAPE_LANGUAGE_INTERPRETER_ASSERT_SVH

// Same-cycle implication on clk, disabled while rst is high.
`define TLI_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication on clk, disabled while rst is high.
`define TLI_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/tli_pkg.sv @@
// Shared types, codes and constants of the tape language interpreter.
`default_nettype none

package tli_pkg;

  localparam int BUDGET_W          = 17;
  localparam logic [BUDGET_W-1:0] BUDGET_RESET = 17'h10000;

  localparam int TAPE_CELLS_DEF    = 256;
  localparam int PROGRAM_DEPTH_DEF = 1024;
  localparam int LOOP_DEPTH_DEF    = 64;

  // Actions
  localparam logic [1:0] ACT_LOAD  = 2'd0;
  localparam logic [1:0] ACT_STEP  = 2'd1;
  localparam logic [1:0] ACT_CLEAR = 2'd2;

  // Result status codes
  localparam logic [3:0] ST_LOADED     = 4'd0;
  localparam logic [3:0] ST_STEPPED    = 4'd1;
  localparam logic [3:0] ST_CHAR       = 4'd2;
  localparam logic [3:0] ST_DONE       = 4'd3;
  localparam logic [3:0] ST_DONE_QUIET = 4'd4;
  localparam logic [3:0] ST_ABORTED    = 4'd5;
  localparam logic [3:0] ST_BRACKET    = 4'd6;
  localparam logic [3:0] ST_COMMA      = 4'd7;
  localparam logic [3:0] ST_FULL       = 4'd8;
  localparam logic [3:0] ST_OVERFLOW   = 4'd9;

  // Program characters
  localparam logic [7:0] CH_PLUS     = 8'h2B;
  localparam logic [7:0] CH_MINUS    = 8'h2D;
  localparam logic [7:0] CH_RIGHT    = 8'h3E;
  localparam logic [7:0] CH_LEFT     = 8'h3C;
  localparam logic [7:0] CH_LBRACK   = 8'h5B;
  localparam logic [7:0] CH_RBRACK   = 8'h5D;
  localparam logic [7:0] CH_COMMA    = 8'h2C;
  localparam logic [7:0] CH_DOT      = 8'h2E;
  localparam logic [7:0] CH_QUESTION = 8'h3F;
  localparam logic [7:0] PRINT_MIN   = 8'd9;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] code_byte;
  } in_item_t;

  typedef struct packed {
    logic [3:0] status;
    logic [7:0] out_char;
  } out_item_t;

  // Tape commands from the sequencer
  typedef struct packed {
    logic rd;
    logic inc;
    logic dec;
    logic clr;
  } tape_cmd_t;

endpackage

`default_nettype wire

@@ rtl/tli_ram.sv @@
// Generic simple dual-port RAM with registered read data.
`default_nettype none

module tli_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port, holds between reads
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

@@ rtl/tli_tape.sv @@
// Tape memory with in-place increment/decrement and a zeroing sweep.
`default_nettype none

module tli_tape #(
  parameter int TAPE_CELLS = tli_pkg::TAPE_CELLS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire tli_pkg::tape_cmd_t            cmd,
  input  wire logic [$clog2(TAPE_CELLS)-1:0] addr,
  output logic      [7:0]                    rdata,
  output logic                               busy
);

  localparam int TA_W = $clog2(TAPE_CELLS);

  logic            sweeping;
  logic [TA_W-1:0] sweep_addr;
  logic            ram_we;
  logic [TA_W-1:0] ram_waddr;
  logic [7:0]      ram_wdata;

  // Zero every cell after reset and after a clear
  always_ff @(posedge clk) begin
    if (rst) begin
      sweeping   <= 1'b1;
      sweep_addr <= '0;
    end else if (cmd.clr) begin
      sweeping   <= 1'b1;
      sweep_addr <= '0;
    end else if (sweeping) begin
      if (sweep_addr == TA_W'(TAPE_CELLS - 1)) begin
        sweeping <= 1'b0;
      end
      sweep_addr <= sweep_addr + TA_W'(1);
    end
  end

  // Write back the modified cell, read data still holds the old value
  always_comb begin
    ram_we    = sweeping | cmd.inc | cmd.dec;
    ram_waddr = sweeping ? sweep_addr : addr;
    if (sweeping) begin
      ram_wdata = '0;
    end else if (cmd.inc) begin
      ram_wdata = rdata + 8'd1;
    end else begin
      ram_wdata = rdata - 8'd1;
    end
  end

  tli_ram #(
    .WIDTH (8),
    .DEPTH (TAPE_CELLS)
  ) u_tape_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (cmd.rd),
    .raddr (addr),
    .rdata (rdata)
  );

  assign busy = sweeping;

endmodule

`default_nettype wire

@@ rtl/tape_language_interpreter.sv @@
// Top level of the tape language interpreter: sequencer, program and loop stack memories.
//
// One transaction is handled at a time. A load, a clear, an unused action or a step that
// does not reach the memories goes from acceptance straight to the response phase. A step
// that does passes an issue phase, reading the program store, the tape cell and the loop
// stack top, an execute phase, decoding the character and writing tape or stack back, and
// a response phase, moving the result into the output register once that is free. A new
// character is taken only after the previous result has entered the output register.
// After reset and after every clear the tape is zeroed by a sweep of all TAPE_CELLS cells,
// during which in_ready stays low; configuration writes are taken at any time.
`default_nettype none
`include "tape_language_interpreter_assert.svh"

module tape_language_interpreter #(
  parameter int TAPE_CELLS    = tli_pkg::TAPE_CELLS_DEF,
  parameter int PROGRAM_DEPTH = tli_pkg::PROGRAM_DEPTH_DEF,
  parameter int LOOP_DEPTH    = tli_pkg::LOOP_DEPTH_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         cfg_wr_en,
  input  wire logic [tli_pkg::BUDGET_W-1:0] cfg_wr_data,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire tli_pkg::in_item_t            in_data,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output tli_pkg::out_item_t                out_data
);

  localparam int TA_W = $clog2(TAPE_CELLS);
  localparam int PA_W = $clog2(PROGRAM_DEPTH);
  localparam int PC_W = $clog2(PROGRAM_DEPTH + 1);
  localparam int SA_W = $clog2(LOOP_DEPTH);
  localparam int LC_W = $clog2(LOOP_DEPTH + 1);
  localparam int BW   = tli_pkg::BUDGET_W;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_RESP = 2'd2;

  logic [1:0]         state;
  logic [1:0]         state_next;
  logic [BW-1:0]      step_budget;
  logic [BW-1:0]      budget_left;
  logic [PC_W-1:0]    prog_len;
  logic [PC_W-1:0]    pc;
  logic [TA_W-1:0]    ptr;
  logic [LC_W-1:0]    loop_count;
  logic               printed;
  logic [3:0]         final_status;
  tli_pkg::out_item_t result;

  logic               accept;
  logic               out_free;
  logic               step_go;
  logic               prog_we;
  logic               stack_we;
  logic [LC_W-1:0]    loop_dec;
  logic [PC_W-1:0]    pc_inc;
  logic [3:0]         end_code;
  logic [7:0]         dot_char;
  logic               plain_out;
  logic [7:0]         prog_rdata;
  logic [PA_W-1:0]    stack_rdata;
  logic [7:0]         tape_rdata;
  logic               tape_busy;
  tli_pkg::tape_cmd_t tape_cmd;

  assign accept    = in_valid & in_ready;
  assign in_ready  = (state == S_IDLE) & ~tape_busy;
  assign out_free  = ~out_valid | out_ready;
  assign loop_dec  = loop_count - LC_W'(1);
  assign pc_inc    = pc + PC_W'(1);
  assign end_code  = printed ? tli_pkg::ST_DONE : tli_pkg::ST_DONE_QUIET;
  assign dot_char  = (tape_rdata < tli_pkg::PRINT_MIN) ? tli_pkg::CH_QUESTION : tape_rdata;
  assign plain_out = out_valid && (out_data.status != tli_pkg::ST_CHAR);

  // Decide when a step really reaches the memories
  assign step_go = accept && (in_data.action == tli_pkg::ACT_STEP) &&
                   (final_status == tli_pkg::ST_LOADED) && (pc < prog_len) &&
                   (budget_left != '0);
  assign prog_we = accept && (in_data.action == tli_pkg::ACT_LOAD) &&
                   (prog_len < PC_W'(PROGRAM_DEPTH));

  // Tape and stack commands: reads and clear on acceptance, writes during execute
  always_comb begin
    tape_cmd.rd  = step_go;
    tape_cmd.inc = (state == S_EXEC) && (prog_rdata == tli_pkg::CH_PLUS);
    tape_cmd.dec = (state == S_EXEC) && (prog_rdata == tli_pkg::CH_MINUS);
    tape_cmd.clr = accept && (in_data.action == tli_pkg::ACT_CLEAR);
    stack_we     = (state == S_EXEC) && (prog_rdata == tli_pkg::CH_LBRACK) &&
                   (loop_count != LC_W'(LOOP_DEPTH));
  end

  // Sequence the phases of one transaction
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = step_go ? S_EXEC : S_RESP;
        end
      end
      S_EXEC: state_next = S_RESP;
      S_RESP: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Interpreter state and result
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      step_budget  <= tli_pkg::BUDGET_RESET;
      budget_left  <= tli_pkg::BUDGET_RESET;
      prog_len     <= '0;
      pc           <= '0;
      ptr          <= '0;
      loop_count   <= '0;
      printed      <= 1'b0;
      final_status <= tli_pkg::ST_LOADED;
    end else begin
      state <= state_next;
      if (cfg_wr_en) begin
        step_budget <= cfg_wr_data;
      end

      if (accept) begin
        case (in_data.action)
          tli_pkg::ACT_LOAD: begin
            if (prog_len < PC_W'(PROGRAM_DEPTH)) begin
              prog_len <= prog_len + PC_W'(1);
              result   <= '{tli_pkg::ST_LOADED, 8'h00};
            end else begin
              result <= '{tli_pkg::ST_FULL, 8'h00};
            end
          end
          tli_pkg::ACT_STEP: begin
            if (final_status != tli_pkg::ST_LOADED) begin
              result <= '{final_status, 8'h00};
            end else if (pc >= prog_len) begin
              final_status <= end_code;
              result       <= '{end_code, 8'h00};
            end else if (budget_left == '0) begin
              final_status <= tli_pkg::ST_ABORTED;
              result       <= '{tli_pkg::ST_ABORTED, 8'h00};
            end else begin
              budget_left <= budget_left - BW'(1);
            end
          end
          tli_pkg::ACT_CLEAR: begin
            prog_len     <= '0;
            pc           <= '0;
            ptr          <= '0;
            loop_count   <= '0;
            budget_left  <= step_budget;
            printed      <= 1'b0;
            final_status <= tli_pkg::ST_LOADED;
            result       <= '{tli_pkg::ST_LOADED, 8'h00};
          end
          default: begin
            result <= '{tli_pkg::ST_LOADED, 8'h00};
          end
        endcase
      end else if (state == S_EXEC) begin
        // Execute the fetched character
        case (prog_rdata)
          tli_pkg::CH_RIGHT: begin
            ptr    <= (ptr == TA_W'(TAPE_CELLS - 1)) ? '0 : ptr + TA_W'(1);
            pc     <= pc_inc;
            result <= '{tli_pkg::ST_STEPPED, 8'h00};
          end
          tli_pkg::CH_LEFT: begin
            ptr    <= (ptr == '0) ? TA_W'(TAPE_CELLS - 1) : ptr - TA_W'(1);
            pc     <= pc_inc;
            result <= '{tli_pkg::ST_STEPPED, 8'h00};
          end
          tli_pkg::CH_LBRACK: begin
            if (loop_count == LC_W'(LOOP_DEPTH)) begin
              final_status <= tli_pkg::ST_OVERFLOW;
              result       <= '{tli_pkg::ST_OVERFLOW, 8'h00};
            end else begin
              loop_count <= loop_count + LC_W'(1);
              pc         <= pc_inc;
              result     <= '{tli_pkg::ST_STEPPED, 8'h00};
            end
          end
          tli_pkg::CH_RBRACK: begin
            if (loop_count == '0) begin
              final_status <= tli_pkg::ST_BRACKET;
              result       <= '{tli_pkg::ST_BRACKET, 8'h00};
            end else if (tape_rdata != '0) begin
              loop_count <= loop_dec;
              pc         <= PC_W'(stack_rdata);
              result     <= '{tli_pkg::ST_STEPPED, 8'h00};
            end else begin
              pc     <= pc_inc;
              result <= '{tli_pkg::ST_STEPPED, 8'h00};
            end
          end
          tli_pkg::CH_COMMA: begin
            final_status <= tli_pkg::ST_COMMA;
            result       <= '{tli_pkg::ST_COMMA, 8'h00};
          end
          tli_pkg::CH_DOT: begin
            printed <= 1'b1;
            pc      <= pc_inc;
            result  <= '{tli_pkg::ST_CHAR, dot_char};
          end
          default: begin
            pc     <= pc_inc;
            result <= '{tli_pkg::ST_STEPPED, 8'h00};
          end
        endcase
      end
    end
  end

  // Output register: load from the response phase, drain on handshake
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      if ((state == S_RESP) && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_RESP) && out_free) begin
      out_data <= result;
    end
  end

  tli_ram #(
    .WIDTH (8),
    .DEPTH (PROGRAM_DEPTH)
  ) u_prog_ram (
    .clk   (clk),
    .we    (prog_we),
    .waddr (prog_len[PA_W-1:0]),
    .wdata (in_data.code_byte),
    .re    (step_go),
    .raddr (pc[PA_W-1:0]),
    .rdata (prog_rdata)
  );

  tli_ram #(
    .WIDTH (PA_W),
    .DEPTH (LOOP_DEPTH)
  ) u_stack_ram (
    .clk   (clk),
    .we    (stack_we),
    .waddr (loop_count[SA_W-1:0]),
    .wdata (pc[PA_W-1:0]),
    .re    (step_go),
    .raddr (loop_dec[SA_W-1:0]),
    .rdata (stack_rdata)
  );

  tli_tape #(
    .TAPE_CELLS (TAPE_CELLS)
  ) u_tape (
    .clk   (clk),
    .rst   (rst),
    .cmd   (tape_cmd),
    .addr  (ptr),
    .rdata (tape_rdata),
    .busy  (tape_busy)
  );

  `TLI_ASSERT_IMPL(a_no_accept_sweep, accept, !tape_busy, "accepted during tape sweep")
  `TLI_ASSERT_IMPL(a_loop_bound, 1'b1, loop_count <= LC_W'(LOOP_DEPTH), "loop stack overrun")
  `TLI_ASSERT_IMPL(a_pc_bound, 1'b1, pc <= prog_len, "program counter past program end")
  `TLI_ASSERT_IMPL(a_char_only, plain_out, out_data.out_char == 8'd0, "stray character")
  `TLI_ASSERT_NEXT(a_exec_once, state == S_EXEC, state == S_RESP, "execute phase stuck")

endmodule

`default_nettype wire
